>>> hdl/slce_pkg.sv
`timescale 1ns / 1ps

package slce_pkg;

  // Line store geometry and command word size
  localparam int LINE_CAPACITY = 32;
  localparam int LINE_AW       = $clog2(LINE_CAPACITY);
  localparam int WORD_CHARS    = 7;
  localparam int TEXT_W        = 8 * WORD_CHARS;
  localparam int WLEN_W        = $clog2(WORD_CHARS + 1);
  localparam int STEP_W        = 3;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Result kinds as they appear on the output port
  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_PROMPT = 2'd2
  } kind_e;

  // Class of a received byte, given the current line
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_STORE,
    CLS_ERASE,
    CLS_ENTER
  } byte_class_e;

  // Which result word the output register is loaded with
  typedef enum logic [2:0] {
    IT_CHAR,
    IT_BS,
    IT_SP,
    IT_CR,
    IT_LF,
    IT_CMD,
    IT_PROMPT
  } item_e;

  // Echo sequences
  typedef enum logic [1:0] {
    SEQ_CHAR,
    SEQ_ERASE,
    SEQ_ENTER
  } seq_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_CMD
  } ctrl_state_e;

  // Parse phase while the stored line streams past
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WORD,
    PH_ARG_SP,
    PH_DIGITS,
    PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic  latch;
    logic  store;
    logic  erase;
    logic  clear;
    logic  scan_start;
    logic  scan_step;
    logic  load;
    item_e item;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    byte_class_e cls;
    logic        line_nonempty;
    logic        out_free;
    logic        scan_done;
  } dp_status_t;

  // Word sent at a given step of a sequence
  function automatic item_e seq_item(input seq_e seq, input logic [STEP_W-1:0] step);
    item_e it;
    it = IT_PROMPT;
    unique case (seq)
      SEQ_CHAR:  it = IT_CHAR;
      SEQ_ERASE: it = (step == STEP_W'(1)) ? IT_SP : IT_BS;
      SEQ_ENTER: begin
        if (step == STEP_W'(0) || step == STEP_W'(2)) begin
          it = IT_CR;
        end else if (step == STEP_W'(1) || step == STEP_W'(3)) begin
          it = IT_LF;
        end else begin
          it = IT_PROMPT;
        end
      end
      default: it = IT_PROMPT;
    endcase
    return it;
  endfunction

  // Final step of a sequence
  function automatic logic seq_last(input seq_e seq, input logic [STEP_W-1:0] step);
    logic l;
    l = 1'b1;
    unique case (seq)
      SEQ_CHAR:  l = 1'b1;
      SEQ_ERASE: l = (step == STEP_W'(2));
      SEQ_ENTER: l = (step == STEP_W'(4));
      default:   l = 1'b1;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/slce_ram.sv
`timescale 1ns / 1ps

module slce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/slce_datapath.sv
`timescale 1ns / 1ps

module slce_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_stall_i,
  input  slce_pkg::dp_cmd_t      cmd_i,
  output slce_pkg::dp_status_t   status_o,
  output logic                   out_valid_o,
  output logic [1:0]             kind_o,
  output logic [7:0]             echo_byte_o,
  output logic [slce_pkg::TEXT_W-1:0] cmd_text_o,
  output logic [2:0]             cmd_length_o,
  output logic signed [31:0]     arg_value_o,
  output logic                   last_o
);

  logic [slce_pkg::LINE_AW-1:0] len_q, len_d;
  logic [7:0]                   byte_q;

  logic [slce_pkg::LINE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic                         rd_pend_q, rd_pend_d;
  logic                         rd_en;
  logic [7:0]                   rd_data;

  slce_pkg::parse_phase_e       phase_q, phase_d;
  logic [slce_pkg::TEXT_W-1:0]  text_q, text_d, add_text;
  logic [slce_pkg::WLEN_W-1:0]  wlen_q, wlen_d, add_wlen;
  logic [31:0]                  val_q, val_d, dig_val;
  logic                         is_sp, is_plus, is_dig;

  logic                         out_valid_q;
  slce_pkg::kind_e              kind_q;
  logic [7:0]                   echo_q;
  logic [slce_pkg::TEXT_W-1:0]  otext_q;
  logic [2:0]                   olen_q;
  logic [31:0]                  oval_q;
  logic                         last_q;

  slce_pkg::kind_e              ld_kind;
  logic [7:0]                   ld_echo;
  logic [slce_pkg::TEXT_W-1:0]  ld_text;
  logic [2:0]                   ld_len;
  logic [31:0]                  ld_val;

  // Line store
  assign rd_en = cmd_i.scan_step && (rd_ptr_q < len_q);

  slce_ram #(
    .WIDTH (8),
    .DEPTH (slce_pkg::LINE_CAPACITY)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (len_q),
    .wdata_i (rx_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // Byte class and status
  always_comb begin
    status_o.cls = slce_pkg::CLS_NONE;
    if (rx_byte_i == slce_pkg::CH_CR) begin
      status_o.cls = slce_pkg::CLS_ENTER;
    end else if (rx_byte_i == slce_pkg::CH_BS || rx_byte_i == slce_pkg::CH_DEL) begin
      if (len_q != '0) begin
        status_o.cls = slce_pkg::CLS_ERASE;
      end
    end else if (rx_byte_i >= slce_pkg::CH_SPACE && rx_byte_i <= slce_pkg::CH_TILDE) begin
      if (len_q < slce_pkg::LINE_AW'(slce_pkg::LINE_CAPACITY - 1)) begin
        status_o.cls = slce_pkg::CLS_STORE;
      end
    end
    status_o.line_nonempty = (len_q != '0);
    status_o.out_free      = !out_valid_q || !out_stall_i;
    status_o.scan_done     = (rd_ptr_q == len_q) && !rd_pend_q;
  end

  // Line length
  always_comb begin
    len_d = len_q;
    if (cmd_i.clear) begin
      len_d = '0;
    end else if (cmd_i.store) begin
      len_d = len_q + 1'b1;
    end else if (cmd_i.erase) begin
      len_d = len_q - 1'b1;
    end
  end

  // Character tests on the byte read back
  assign is_sp   = (rd_data == slce_pkg::CH_SPACE);
  assign is_plus = (rd_data == slce_pkg::CH_PLUS);
  assign is_dig  = (rd_data >= slce_pkg::CH_ZERO) && (rd_data <= slce_pkg::CH_NINE);
  assign dig_val = (val_q << 3) + (val_q << 1) + {28'd0, rd_data[3:0]};

  // Append to command word, dropping characters past the word limit
  always_comb begin
    add_text = text_q;
    add_wlen = wlen_q;
    if (wlen_q < slce_pkg::WLEN_W'(slce_pkg::WORD_CHARS)) begin
      for (int i = 0; i < slce_pkg::WORD_CHARS; i++) begin
        if (wlen_q == slce_pkg::WLEN_W'(i)) begin
          add_text[i*8 +: 8] = rd_data;
        end
      end
      add_wlen = wlen_q + 1'b1;
    end
  end

  // Scan: one read issued and one byte evaluated per cycle
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    rd_pend_d = rd_pend_q;
    phase_d   = phase_q;
    text_d    = text_q;
    wlen_d    = wlen_q;
    val_d     = val_q;
    if (cmd_i.scan_start) begin
      rd_ptr_d  = '0;
      rd_pend_d = 1'b0;
      phase_d   = slce_pkg::PH_LEAD;
      text_d    = '0;
      wlen_d    = '0;
      val_d     = '0;
    end else if (cmd_i.scan_step) begin
      rd_pend_d = rd_en;
      if (rd_en) begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
      if (rd_pend_q) begin
        unique case (phase_q)
          slce_pkg::PH_LEAD: begin
            if (!is_sp) begin
              text_d  = add_text;
              wlen_d  = add_wlen;
              phase_d = slce_pkg::PH_WORD;
            end
          end
          slce_pkg::PH_WORD: begin
            if (is_sp) begin
              phase_d = slce_pkg::PH_ARG_SP;
            end else begin
              text_d = add_text;
              wlen_d = add_wlen;
            end
          end
          slce_pkg::PH_ARG_SP: begin
            if (is_plus) begin
              phase_d = slce_pkg::PH_DIGITS;
            end else if (is_dig) begin
              val_d   = dig_val;
              phase_d = slce_pkg::PH_DIGITS;
            end else if (!is_sp) begin
              phase_d = slce_pkg::PH_DONE;
            end
          end
          slce_pkg::PH_DIGITS: begin
            if (is_dig) begin
              val_d = dig_val;
            end else begin
              phase_d = slce_pkg::PH_DONE;
            end
          end
          slce_pkg::PH_DONE: phase_d = slce_pkg::PH_DONE;
          default:           phase_d = slce_pkg::PH_DONE;
        endcase
      end
    end
  end

  // Result word decode
  always_comb begin
    ld_kind = slce_pkg::KIND_ECHO;
    ld_echo = '0;
    ld_text = '0;
    ld_len  = '0;
    ld_val  = '0;
    unique case (cmd_i.item)
      slce_pkg::IT_CHAR:   ld_echo = byte_q;
      slce_pkg::IT_BS:     ld_echo = slce_pkg::CH_BS;
      slce_pkg::IT_SP:     ld_echo = slce_pkg::CH_SPACE;
      slce_pkg::IT_CR:     ld_echo = slce_pkg::CH_CR;
      slce_pkg::IT_LF:     ld_echo = slce_pkg::CH_LF;
      slce_pkg::IT_CMD: begin
        ld_kind = slce_pkg::KIND_CMD;
        ld_text = text_q;
        ld_len  = 3'(wlen_q);
        ld_val  = val_q;
      end
      slce_pkg::IT_PROMPT: ld_kind = slce_pkg::KIND_PROMPT;
      default:             ld_kind = slce_pkg::KIND_PROMPT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rd_ptr_q    <= '0;
      rd_pend_q   <= 1'b0;
      phase_q     <= slce_pkg::PH_LEAD;
      out_valid_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_pend_q <= rd_pend_d;
      phase_q   <= phase_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= rx_byte_i;
    end
    text_q <= text_d;
    wlen_q <= wlen_d;
    val_q  <= val_d;
    if (cmd_i.load) begin
      kind_q  <= ld_kind;
      echo_q  <= ld_echo;
      otext_q <= ld_text;
      olen_q  <= ld_len;
      oval_q  <= ld_val;
      last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign echo_byte_o  = echo_q;
  assign cmd_text_o   = otext_q;
  assign cmd_length_o = olen_q;
  assign arg_value_o  = signed'(oval_q);
  assign last_o       = last_q;

endmodule

>>> hdl/slce_ctrl.sv
`timescale 1ns / 1ps

module slce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slce_pkg::dp_status_t status_i,
  output slce_pkg::dp_cmd_t    cmd_o
);

  slce_pkg::ctrl_state_e        state_q, state_d;
  slce_pkg::seq_e               seq_q, seq_d;
  logic [slce_pkg::STEP_W-1:0]  step_q, step_d;
  logic                         accept;
  logic                         cur_last;

  assign accept   = in_valid_i && (state_q == slce_pkg::ST_IDLE);
  assign cur_last = slce_pkg::seq_last(seq_q, step_q);

  // Next state
  always_comb begin
    state_d = state_q;
    seq_d   = seq_q;
    step_d  = step_q;
    unique case (state_q)
      slce_pkg::ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          unique case (status_i.cls)
            slce_pkg::CLS_STORE: begin
              seq_d   = slce_pkg::SEQ_CHAR;
              state_d = slce_pkg::ST_EMIT;
            end
            slce_pkg::CLS_ERASE: begin
              seq_d   = slce_pkg::SEQ_ERASE;
              state_d = slce_pkg::ST_EMIT;
            end
            slce_pkg::CLS_ENTER: begin
              seq_d   = slce_pkg::SEQ_ENTER;
              state_d = slce_pkg::ST_EMIT;
            end
            slce_pkg::CLS_NONE: state_d = slce_pkg::ST_IDLE;
            default:            state_d = slce_pkg::ST_IDLE;
          endcase
        end
      end
      slce_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          step_d = step_q + 1'b1;
          if (cur_last) begin
            state_d = slce_pkg::ST_IDLE;
          end else if (seq_q == slce_pkg::SEQ_ENTER && step_q == slce_pkg::STEP_W'(1) &&
                       status_i.line_nonempty) begin
            state_d = slce_pkg::ST_SCAN;
          end
        end
      end
      slce_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = slce_pkg::ST_CMD;
        end
      end
      slce_pkg::ST_CMD: begin
        if (status_i.out_free) begin
          state_d = slce_pkg::ST_EMIT;
        end
      end
      default: state_d = slce_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.item = slce_pkg::IT_CHAR;
    in_stall_o = (state_q != slce_pkg::ST_IDLE);
    unique case (state_q)
      slce_pkg::ST_IDLE: begin
        cmd_o.latch = accept;
        cmd_o.store = accept && (status_i.cls == slce_pkg::CLS_STORE);
        cmd_o.erase = accept && (status_i.cls == slce_pkg::CLS_ERASE);
      end
      slce_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load       = 1'b1;
          cmd_o.item       = slce_pkg::seq_item(seq_q, step_q);
          cmd_o.last       = cur_last;
          cmd_o.scan_start = !cur_last && (seq_q == slce_pkg::SEQ_ENTER) &&
                             (step_q == slce_pkg::STEP_W'(1)) && status_i.line_nonempty;
        end
      end
      slce_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      slce_pkg::ST_CMD: begin
        if (status_i.out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.item  = slce_pkg::IT_CMD;
          cmd_o.clear = 1'b1;
        end
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slce_pkg::ST_IDLE;
      seq_q   <= slce_pkg::SEQ_CHAR;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      seq_q   <= seq_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> hdl/serial_line_editor_command_parser_unit.sv
`timescale 1ns / 1ps

// Line editor for a serial console. Each received byte (one word on the input
// channel) edits a line of up to 31 characters and produces zero to six words
// on the output channel: echo bytes, one command word when a non-empty line is
// entered (first token up to 7 characters, plus a decimal argument), and a
// prompt request. The last word caused by a byte carries last_o. One byte is
// handled at a time; in_stall_o is high until its final word sits in the
// output register, so the next byte can be taken while that word waits. A
// carriage return on a non-empty line starts a scan of the line store through
// its single read port, one byte per cycle. Output stalls hold back each word.
module serial_line_editor_command_parser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  echo_byte_o,
  output logic [slce_pkg::TEXT_W-1:0] cmd_text_o,
  output logic [2:0]                  cmd_length_o,
  output logic signed [31:0]          arg_value_o,
  output logic                        last_o
);

  slce_pkg::dp_cmd_t    dp_cmd;
  slce_pkg::dp_status_t dp_status;

  // Sequencer
  slce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Line store, parser and output register
  slce_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .echo_byte_o  (echo_byte_o),
    .cmd_text_o   (cmd_text_o),
    .cmd_length_o (cmd_length_o),
    .arg_value_o  (arg_value_o),
    .last_o       (last_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import slce_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 370;

  // One word on the output channel, as the line editor should produce it
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        echo;
    logic [TEXT_W-1:0] text;
    logic [2:0]        len;
    logic [31:0]       arg;
    logic              last;
  } line_word_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                in_valid = 1'b0;
  logic [7:0]          rx_byte  = 8'd0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          kind;
  logic [7:0]          echo_byte;
  logic [TEXT_W-1:0]   cmd_text;
  logic [2:0]          cmd_length;
  logic signed [31:0]  arg_value;
  logic                last;

  logic [7:0]  rx_pending[$];
  line_word_t  expected_words[$];
  int          n_rx_queued = 0;
  int          n_rx_taken  = 0;
  int          n_useful    = 0;
  int          n_err       = 0;
  int          idle_cycles = 0;

  // Shadow of the line being edited
  logic [7:0]  line_buf [LINE_CAPACITY];
  int          line_len = 0;

  wire quiet = (n_rx_taken >= 200) && (n_rx_taken < 300);

  serial_line_editor_command_parser_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .echo_byte_o  (echo_byte),
    .cmd_text_o   (cmd_text),
    .cmd_length_o (cmd_length),
    .arg_value_o  (arg_value),
    .last_o       (last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic line_word_t echo_word(input logic [7:0] c);
    line_word_t w;
    w      = '0;
    w.kind = KIND_ECHO;
    w.echo = c;
    return w;
  endfunction

  // Parse the shadow line: word after leading spaces, then the decimal argument
  function automatic line_word_t command_word();
    line_word_t  w;
    int          p;
    int          wl;
    logic [31:0] v;
    w  = '0;
    p  = 0;
    wl = 0;
    v  = '0;
    while (p < line_len && line_buf[p] == CH_SPACE) p++;
    while (p < line_len && line_buf[p] != CH_SPACE) begin
      if (wl < WORD_CHARS) begin
        w.text[8*wl +: 8] = line_buf[p];
        wl++;
      end
      p++;
    end
    if (p < line_len) begin
      p++;
      while (p < line_len && line_buf[p] == CH_SPACE) p++;
      if (p < line_len && line_buf[p] == CH_PLUS) p++;
      while (p < line_len && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE) begin
        v = v * 32'd10 + 32'(line_buf[p] - CH_ZERO);
        p++;
      end
    end
    w.kind = KIND_CMD;
    w.len  = 3'(wl);
    w.arg  = v;
    return w;
  endfunction

  // Apply one received byte to the shadow line and queue the words it causes
  task automatic edit_line(input logic [7:0] c);
    line_word_t words[$];
    line_word_t w;
    if (c == CH_CR) begin
      words.push_back(echo_word(CH_CR));
      words.push_back(echo_word(CH_LF));
      if (line_len > 0) words.push_back(command_word());
      line_len = 0;
      words.push_back(echo_word(CH_CR));
      words.push_back(echo_word(CH_LF));
      w      = '0;
      w.kind = KIND_PROMPT;
      words.push_back(w);
    end else if (c == CH_BS || c == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        words.push_back(echo_word(CH_BS));
        words.push_back(echo_word(CH_SPACE));
        words.push_back(echo_word(CH_BS));
      end
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      if (line_len < LINE_CAPACITY - 1) begin
        line_buf[line_len] = c;
        line_len++;
        words.push_back(echo_word(c));
      end
    end
    if (words.size() > 0) begin
      w      = words.pop_back();
      w.last = 1'b1;
      words.push_back(w);
    end
    foreach (words[i]) expected_words.push_back(words[i]);
  endtask

  task automatic push_byte(input logic [7:0] c);
    rx_pending.push_back(c);
    if (c == CH_CR || c == CH_BS || c == CH_DEL || (c >= CH_SPACE && c <= CH_TILDE))
      n_useful++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Driver: offer bytes from the pending queue, hold them while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        edit_line(rx_byte);
        n_rx_taken <= n_rx_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (rx_pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted word, stall at random and once for a long spell
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    line_word_t w;
    int         hold_left;
    bit         hold_done;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (n_err < 10)
            $display("unexpected word: kind %0d echo %h text %h len %0d arg %0d last %0d",
                     kind, echo_byte, cmd_text, cmd_length, arg_value, last);
          n_err++;
        end else begin
          w = expected_words.pop_front();
          if (kind !== w.kind || echo_byte !== w.echo || cmd_text !== w.text ||
              cmd_length !== w.len || arg_value !== w.arg || last !== w.last) begin
            if (n_err < 10) begin
              $display("mismatch exp: kind %0d echo %h text %h len %0d arg %0d last %0d",
                       w.kind, w.echo, w.text, w.len, $signed(w.arg), w.last);
              $display("         got: kind %0d echo %h text %h len %0d arg %0d last %0d",
                       kind, echo_byte, cmd_text, cmd_length, arg_value, last);
            end
            n_err++;
          end
        end
      end
      if (!hold_done && n_rx_taken >= 60) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 23);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int sel;
    int iter;
    int word_len;
    int n_dig;
    int n;
    // Directed: ignored bytes, empty-line backspace and enter, edits, spaces
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_byte(CH_BS);
    push_byte(CH_DEL);
    push_byte(8'd31);
    push_byte(8'd128);
    push_text(" ~");
    push_byte(CH_CR);
    push_text("ab +12");
    push_byte(CH_BS);
    push_text("9");
    push_byte(CH_CR);
    push_text("  ");
    push_byte(CH_CR);
    push_text("q");
    push_byte(CH_DEL);
    push_byte(CH_CR);

    // Random: mostly well-formed lines, some noise, broken edits and overlong lines
    iter = 0;
    while (n_useful < RANDOM_ITEMS - 20) begin
      if (iter == 0) sel = 97;
      else if (iter == 1) sel = 0;
      else sel = $urandom_range(0, 99);
      word_len = (iter == 1) ? 11 : $urandom_range(0, 9);
      n_dig    = (iter == 1) ? 12 : (($urandom_range(0, 5) == 0) ? $urandom_range(10, 12)
                                                               : $urandom_range(0, 4));
      if (sel < 70) begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) push_byte(CH_SPACE);
        repeat (word_len) push_byte(8'($urandom_range(33, 126)));
        if (iter == 1 || $urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 3)) push_byte(CH_SPACE);
          if ($urandom_range(0, 1) == 0) push_byte(CH_PLUS);
          repeat (n_dig) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 3) == 0) push_byte(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 4) == 0) begin
          push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
          push_byte(8'($urandom_range(32, 126)));
        end
        push_byte(CH_CR);
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(32, 126)));
        repeat ($urandom_range(1, 8)) push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
        if ($urandom_range(0, 1) == 0) push_byte(CH_CR);
      end else begin
        // overlong line: the tail past the capacity is dropped
        repeat ($urandom_range(28, 36)) push_byte(8'($urandom_range(32, 126)));
        push_byte(CH_CR);
      end
      iter++;
    end
    n_rx_queued = rx_pending.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_rx_taken < n_rx_queued) @(negedge clk_i);
    while (expected_words.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (expected_words.size() > 0) begin
      if (n_err < 10) $display("%0d words never arrived", expected_words.size());
      n_err += expected_words.size();
    end
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> serial_line_editor_command_parser_unit.f
hdl/slce_pkg.sv
hdl/slce_ram.sv
hdl/slce_datapath.sv
hdl/slce_ctrl.sv
hdl/serial_line_editor_command_parser_unit.sv
sim/testbench.sv
